/* rtl/core/low_frequency_oscillator_macros.svh */
// Assertion macros used by the checker file.
`ifndef LOW_FREQUENCY_OSCILLATOR_MACROS_SVH
`define LOW_FREQUENCY_OSCILLATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFO_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfo check failed");

// Consequent must hold in the cycle after the antecedent sequence.
`define LFO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfo check failed");

`endif

/* rtl/core/lfo_pkg.sv */
`timescale 1ns / 1ps

package lfo_pkg;

  localparam int unsigned LfoPhaseBits    = 32;
  localparam int unsigned LfoSineAddrBits = 10;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [CfgIndexW-1:0] {
    REG_WAVE_SHAPE    = 3'd0,
    REG_PHASE_STEP    = 3'd1,
    REG_DEPTH_GAIN    = 3'd2,
    REG_OUTPUT_OFFSET = 3'd3,
    REG_START_PHASE   = 3'd4
  } lfo_reg_e;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_TRIANGLE = 2'd1,
    SHAPE_SQUARE   = 2'd2,
    SHAPE_SAW      = 2'd3
  } lfo_shape_e;

  // Phase tap handed from the accumulator to the wave stage.
  typedef struct packed {
    logic [15:0] u;
    logic        sine_neg;
  } lfo_tap_t;

  localparam logic [31:0]        ResetPhaseStep   = 32'd89478;
  localparam logic [25:0]        ResetDepthGain   = 26'd65536;
  localparam logic signed [26:0] ResetOutputOffset = 27'sd0;
  localparam logic [31:0]        ResetStartPhase  = 32'd0;

  localparam logic signed [28:0] OutMax = 29'sd131072000;
  localparam logic signed [28:0] OutMin = -29'sd131072000;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Quarter-wave sine entry, Q0.15 magnitude, by a seven-term Taylor series.
  function automatic logic [14:0] sine_entry(int unsigned k, int unsigned addr_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x    = (64'(k) * HalfPiQ30) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (sum * 64'sd32768 + 64'sd536870912) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[14:0];
  endfunction

endpackage

/* rtl/core/lfo_phase_acc.sv */
`timescale 1ns / 1ps

module lfo_phase_acc import lfo_pkg::*; #(
  parameter int unsigned PHASE_BITS     = LfoPhaseBits,
  parameter int unsigned SINE_ADDR_BITS = LfoSineAddrBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  logic                    restart_i,
  input  logic [31:0]             phase_step_i,
  input  logic [31:0]             start_phase_i,
  output logic [SINE_ADDR_BITS:0] rom_addr_o,
  output lfo_tap_t                tap_o
);

  localparam int unsigned AlignShift = 48 - PHASE_BITS;
  localparam logic [SINE_ADDR_BITS:0] Quarter = {1'b1, {SINE_ADDR_BITS{1'b0}}};

  logic [PHASE_BITS-1:0]       phase_q, phase_d;
  logic [PHASE_BITS-1:0]       step_al, start_al, cur;
  logic [SINE_ADDR_BITS+1:0]   top;
  logic [1:0]                  quad;
  logic [SINE_ADDR_BITS-1:0]   idx;
  lfo_tap_t                    tap_q, tap_d;

  // Align 32-bit fractions to the accumulator width.
  assign step_al  = PHASE_BITS'({phase_step_i, 16'h0000} >> AlignShift);
  assign start_al = PHASE_BITS'({start_phase_i, 16'h0000} >> AlignShift);

  assign cur     = restart_i ? start_al : phase_q;
  assign phase_d = advance_i ? cur + step_al : phase_q;

  assign top  = cur[PHASE_BITS-1 -: SINE_ADDR_BITS+2];
  assign quad = top[SINE_ADDR_BITS+1:SINE_ADDR_BITS];
  assign idx  = top[SINE_ADDR_BITS-1:0];

  assign rom_addr_o = quad[0] ? Quarter - {1'b0, idx} : {1'b0, idx};

  always_comb begin
    tap_d.u        = cur[PHASE_BITS-1 -: 16];
    tap_d.sine_neg = quad[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      tap_q <= tap_d;
    end
  end

  assign tap_o = tap_q;

endmodule

/* rtl/core/lfo_sine_rom.sv */
`timescale 1ns / 1ps

module lfo_sine_rom import lfo_pkg::*; #(
  parameter int unsigned SINE_ADDR_BITS = LfoSineAddrBits
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [SINE_ADDR_BITS:0] addr_i,
  output logic [14:0]             data_o
);

  localparam int unsigned RomDepth = (1 << SINE_ADDR_BITS) + 1;

  logic [14:0] rom_tbl [RomDepth];
  logic [14:0] data_q;

  for (genvar k = 0; k < RomDepth; k++) begin : g_rom
    assign rom_tbl[k] = sine_entry(k, SINE_ADDR_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom_tbl[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

/* rtl/core/lfo_scale.sv */
`timescale 1ns / 1ps

module lfo_scale import lfo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s1_valid_i,
  input  lfo_tap_t           tap_i,
  input  logic [14:0]        sine_i,
  input  lfo_shape_e         wave_shape_i,
  input  logic [25:0]        depth_gain_i,
  input  logic signed [26:0] output_offset_i,
  output logic               s1_ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [27:0] lfo_value_o
);

  logic               s2_valid_q, out_valid_q;
  logic               s2_ready, out_ready, s2_load, out_load;
  logic signed [15:0] wave, saw, square, sine, tri_w;
  logic signed [16:0] dlt, mag;
  logic signed [17:0] tri_full;
  logic signed [42:0] prod_d, prod_q, rnd;
  logic signed [27:0] scaled;
  logic signed [28:0] total;
  logic signed [27:0] value_d, value_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready_o = s2_ready;
  assign s2_load    = s1_valid_i && s2_ready;
  assign out_load   = s2_valid_q && out_ready;

  // Wave select.
  always_comb begin
    saw      = $signed({~tap_i.u[15], tap_i.u[14:0]});
    square   = tap_i.u[15] ? 16'sh8000 : 16'sh7fff;
    sine     = tap_i.sine_neg ? -$signed({1'b0, sine_i}) : $signed({1'b0, sine_i});
    dlt      = $signed({1'b0, tap_i.u}) - 17'sd32768;
    mag      = dlt[16] ? -dlt : dlt;
    tri_full = 18'sd32768 - 18'(2 * 18'(mag));
    tri_w    = (tri_full > 18'sd32767) ? 16'sh7fff : tri_full[15:0];
    case (wave_shape_i)
      SHAPE_SINE:     wave = sine;
      SHAPE_TRIANGLE: wave = tri_w;
      SHAPE_SQUARE:   wave = square;
      SHAPE_SAW:      wave = saw;
      default:        wave = sine;
    endcase
    prod_d = $signed({1'b0, depth_gain_i}) * wave;
  end

  // Round half up, scale by 2^-15, add offset, clamp.
  always_comb begin
    rnd    = prod_q + 43'sd16384;
    scaled = 28'(rnd >>> 15);
    total  = 29'(scaled) + 29'(output_offset_i);
    if (total > OutMax) begin
      value_d = 28'(OutMax);
    end else if (total < OutMin) begin
      value_d = 28'(OutMin);
    end else begin
      value_d = total[27:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= s1_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      prod_q <= prod_d;
    end
    if (out_load) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign lfo_value_o = value_q;

endmodule

/* rtl/core/low_frequency_oscillator.sv */
`timescale 1ns / 1ps
// Pipeline: three register stages; a result waits in the output register while stalled.
// Throughput: one transaction per cycle unless the output stalls. The phase add and the
// registered sine ROM read share stage one, the 27x16 multiply fills stage two, and round,
// offset and clamp fill stage three.
// Reset (async, active low): config registers take their defaults, phase clears to zero,
// all pipeline valids drop. Config writes are always accepted (cfg_ready_o high).
module low_frequency_oscillator import lfo_pkg::*; #(
  parameter int unsigned PHASE_BITS     = LfoPhaseBits,
  parameter int unsigned SINE_ADDR_BITS = LfoSineAddrBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 restart_i,
  // Output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [27:0]   lfo_value_o,
  // Config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  // Config registers.
  lfo_shape_e         wave_shape_q;
  logic [31:0]        phase_step_q;
  logic [25:0]        depth_gain_q;
  logic signed [26:0] output_offset_q;
  logic [31:0]        start_phase_q;

  // Pipeline control.
  logic                    s1_valid_q;
  logic                    s1_ready, advance;
  logic                    s2_ready_from_scale;
  logic [SINE_ADDR_BITS:0] rom_addr;
  logic [14:0]             sine_mag;
  lfo_tap_t                tap;

  assign cfg_ready_o = 1'b1;

  // Decode config writes; indexes past the register list drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_shape_q    <= SHAPE_SINE;
      phase_step_q    <= ResetPhaseStep;
      depth_gain_q    <= ResetDepthGain;
      output_offset_q <= ResetOutputOffset;
      start_phase_q   <= ResetStartPhase;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (lfo_reg_e'(cfg_index_i))
        REG_WAVE_SHAPE:    wave_shape_q    <= lfo_shape_e'(cfg_data_i[1:0]);
        REG_PHASE_STEP:    phase_step_q    <= cfg_data_i;
        REG_DEPTH_GAIN:    depth_gain_q    <= cfg_data_i[25:0];
        REG_OUTPUT_OFFSET: output_offset_q <= $signed(cfg_data_i[26:0]);
        REG_START_PHASE:   start_phase_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Stage 1 holds the phase tap and the ROM word. It frees up when stage 2 can take it, so new
  // transactions keep flowing while a finished result waits at the output, until stage 2 fills.
  assign s1_ready   = !s1_valid_q || s2_ready_from_scale;
  assign in_stall_o = !s1_ready;
  assign advance    = in_valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Phase accumulator: evaluate at the (optionally restarted) phase, then advance.
  lfo_phase_acc #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_phase_acc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .restart_i     (restart_i),
    .phase_step_i  (phase_step_q),
    .start_phase_i (start_phase_q),
    .rom_addr_o    (rom_addr),
    .tap_o         (tap)
  );

  // Quarter-wave sine lookup, read data registered alongside the tap.
  lfo_sine_rom #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .en_i   (advance),
    .addr_i (rom_addr),
    .data_o (sine_mag)
  );

  // Wave select and multiply, then round, offset and clamp into the output register.
  lfo_scale u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s1_valid_i      (s1_valid_q),
    .tap_i           (tap),
    .sine_i          (sine_mag),
    .wave_shape_i    (wave_shape_q),
    .depth_gain_i    (depth_gain_q),
    .output_offset_i (output_offset_q),
    .s1_ready_o      (s2_ready_from_scale),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .lfo_value_o     (lfo_value_o)
  );

endmodule

/* rtl/core/lfo_checker.sv */
`timescale 1ns / 1ps
`include "low_frequency_oscillator_macros.svh"

module lfo_checker import lfo_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 restart_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic signed [27:0]   lfo_value_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CfgIndexW-1:0] cfg_index_i,
  input logic [CfgDataW-1:0]  cfg_data_i
);

  // Results stay inside the clamp range.
  `LFO_ASSERT_IMPLY(a_value_range, out_valid_o, (lfo_value_o <= 28'sd131072000) && (lfo_value_o >= -28'sd131072000))

  // Input backs up only when the whole pipeline is full and the output is stalled.
  `LFO_ASSERT_IMPLY(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // An accepted transaction reaches the output register when nothing stalls on the way.
  `LFO_ASSERT_NEXT(a_latency, (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i, out_valid_o)

  // A stalled result holds.
  `LFO_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(lfo_value_o))

endmodule

bind low_frequency_oscillator lfo_checker u_lfo_checker (.*);

/* tb/low_frequency_oscillator_tb.sv */
`timescale 1ns / 1ps

module low_frequency_oscillator_tb;
  import lfo_pkg::*;

  typedef longint unsigned u64_t;

  localparam int QuarterLen     = 1 << LfoSineAddrBits;
  localparam int IndexShift     = LfoPhaseBits - 2 - LfoSineAddrBits;
  localparam int SettleCycles   = 6;      // pipeline is 3 deep; leave margin
  localparam int CycleLimit     = 200000;
  localparam int LongHoldCycles = 300;
  localparam int ReportLimit    = 10;
  localparam int PhaseCount     = 8;
  localparam int ItemsPerPhase  = 64;

  // First register index that decodes to nothing.
  localparam logic [CfgIndexW-1:0] RegFirstUnmapped = 3'd5;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts from a known value
  // ---------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 restart_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [27:0]   lfo_value_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = REG_WAVE_SHAPE;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;

  always #2 clk_i = ~clk_i;

  low_frequency_oscillator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .lfo_value_o (lfo_value_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Oscillator mirror: register copies, phase and the quarter-wave sine table
  // ---------------------------------------------------------------------------
  lfo_shape_e          shape_m  = SHAPE_SINE;
  logic [31:0]         step_m   = ResetPhaseStep;
  logic [25:0]         depth_m  = ResetDepthGain;
  logic [26:0]         offset_m = ResetOutputOffset;
  logic [31:0]         start_m  = ResetStartPhase;
  logic [31:0]         phase_m  = '0;
  int                  sine_quarter [QuarterLen + 1];

  // Values still owed by the block, oldest first.
  logic signed [27:0]  pending_values [$];
  logic signed [27:0]  oldest_value;
  int                  fault_count = 0;
  int                  cycle_count = 0;

  // Receiver hold-off bookkeeping. The sender bumps hold_requests; the receiver
  // serves each request with one long stall.
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int pattern_left  = 0;
  int stall_pct     = 0;

  // Fill the quarter-wave table with a seven-term Taylor series in Q30.
  function automatic void build_sine_quarter();
    u64_t   x;
    u64_t   x2;
    u64_t   term;
    longint acc;
    longint v;
    for (int k = 0; k <= QuarterLen; k++) begin
      x    = (u64_t'(k) * HalfPiQ30) >> LfoSineAddrBits;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc -= longint'(term);
        end else begin
          acc += longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (acc * 32768 + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) begin
        v = 32767;
      end
      sine_quarter[k] = int'(v);
    end
  endfunction

  // Mirror a register write; unmapped indexes drop the write.
  function automatic void apply_register_write(input logic [CfgIndexW-1:0] idx,
                                               input logic [CfgDataW-1:0]  data);
    case (idx)
      REG_WAVE_SHAPE:    shape_m  = lfo_shape_e'(data[1:0]);
      REG_PHASE_STEP:    step_m   = data;
      REG_DEPTH_GAIN:    depth_m  = data[25:0];
      REG_OUTPUT_OFFSET: offset_m = data[26:0];
      REG_START_PHASE:   start_m  = data;
      default: ;
    endcase
  endfunction

  // Evaluate one tick: optional phase reload, wave lookup, scale, offset,
  // clamp, then advance the phase.
  function automatic logic signed [27:0] lfo_tick(input logic restart);
    logic [15:0] u;
    logic [1:0]  quad;
    int          idx;
    int          w;
    int          d;
    longint      prod;
    longint      total;
    if (restart) begin
      phase_m = start_m;
    end
    u = phase_m[LfoPhaseBits-1 -: 16];
    case (shape_m)
      SHAPE_TRIANGLE: begin
        d = int'(u) - 32768;
        if (d < 0) begin
          d = -d;
        end
        w = 32768 - 2 * d;
        if (w > 32767) begin
          w = 32767;
        end
      end
      SHAPE_SQUARE: w = (u < 16'h8000) ? 32767 : -32768;
      SHAPE_SAW:    w = int'(u) - 32768;
      default: begin
        quad = phase_m[LfoPhaseBits-1 -: 2];
        idx  = int'((phase_m >> IndexShift) & (QuarterLen - 1));
        w    = quad[0] ? sine_quarter[QuarterLen - idx] : sine_quarter[idx];
        if (quad[1]) begin
          w = -w;
        end
      end
    endcase
    // Round half up, then drop 15 fraction bits (floor on the biased product).
    prod  = longint'(depth_m) * longint'(w) + 64'sd16384;
    total = longint'($signed(offset_m)) + (prod >>> 15);
    if (total > longint'(OutMax)) begin
      total = longint'(OutMax);
    end
    if (total < longint'(OutMin)) begin
      total = longint'(OutMin);
    end
    phase_m = phase_m + step_m;
    return total[27:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Directed stimulus. A row either writes a register or offers one tick.
  // Ticks marked typed carry a value worked out by hand; the rest fall back on
  // the mirror.
  // ---------------------------------------------------------------------------
  typedef enum logic {DO_WRITE, DO_TICK} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIndexW-1:0] idx;
    logic [CfgDataW-1:0]  data;
    logic                 restart;
    logic                 typed;
    logic signed [27:0]   value;
  } dir_row_t;

  localparam int DirRows = 40;

  dir_row_t dir_rows [DirRows] = '{
    // Defaults after reset: sine at phase zero, then restart at phase zero.
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b1, 1'b1, 28'sd0},
    // Quarter-cycle step: sine hits zero, peak, zero, trough.
    '{DO_WRITE, REG_PHASE_STEP,    32'h4000_0000, 1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b1, 1'b1, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, 28'sd65534},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, -28'sd65534},
    // Triangle: bottom, zero crossing, saturated top.
    '{DO_WRITE, REG_WAVE_SHAPE,    32'(SHAPE_TRIANGLE), 1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b1, 1'b1, -28'sd65536},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, 28'sd65534},
    // Square: high in the first half, low from one half on.
    '{DO_WRITE, REG_WAVE_SHAPE,    32'(SHAPE_SQUARE), 1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b1, 1'b1, 28'sd65534},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, 28'sd65534},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, -28'sd65536},
    // Saw: most negative, then a quarter up.
    '{DO_WRITE, REG_WAVE_SHAPE,    32'(SHAPE_SAW), 1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b1, 1'b1, -28'sd65536},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, -28'sd32768},
    // Full depth (upper data bits must be dropped) and most positive offset.
    '{DO_WRITE, REG_DEPTH_GAIN,    32'hFFFF_FFFF, 1'b0, 1'b0, 28'sd0},
    '{DO_WRITE, REG_OUTPUT_OFFSET, 32'h03FF_FFFF, 1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b1, 1'b1, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, 28'sd33554432},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, 28'sd67108863},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, 28'sd100663295},
    // Clamp at the positive limit.
    '{DO_WRITE, REG_WAVE_SHAPE,    32'(SHAPE_SQUARE), 1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b1, 1'b1, 28'sd131072000},
    // Most negative offset; clamp at the negative limit.
    '{DO_WRITE, REG_OUTPUT_OFFSET, 32'h0400_0000, 1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b1, -28'sd131072000},
    // Start phase just below one cycle; a write to an unmapped index changes nothing.
    '{DO_WRITE, REG_START_PHASE,   32'hFFFF_FFFF, 1'b0, 1'b0, 28'sd0},
    '{DO_WRITE, RegFirstUnmapped,  32'h0,         1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b1, 1'b1, -28'sd131072000},
    // Sine at phases that read the table near both ends, then a frozen phase.
    '{DO_WRITE, REG_WAVE_SHAPE,    32'(SHAPE_SINE), 1'b0, 1'b0, 28'sd0},
    '{DO_WRITE, REG_DEPTH_GAIN,    32'h0001_0000, 1'b0, 1'b0, 28'sd0},
    '{DO_WRITE, REG_OUTPUT_OFFSET, 32'h0,         1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b1, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b0, 28'sd0},
    '{DO_WRITE, REG_PHASE_STEP,    32'h0,         1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b0, 28'sd0},
    '{DO_TICK,  REG_WAVE_SHAPE,    32'h0,         1'b0, 1'b0, 28'sd0}
  };

  // ---------------------------------------------------------------------------
  // Sender tasks
  // ---------------------------------------------------------------------------

  // Offer one tick and hold it until accepted; record what the block owes.
  task automatic offer_tick(input logic restart, input logic typed,
                            input logic signed [27:0] value);
    logic signed [27:0] predicted;
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    predicted = lfo_tick(restart);
    pending_values.push_back(typed ? value : predicted);
  endtask

  // Send a burst of random ticks, then drop valid for the gap (none if zero).
  task automatic send_burst(input int count, input int gap);
    for (int i = 0; i < count; i++) begin
      offer_tick($urandom_range(0, 11) == 0, 1'b0, '0);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every owed result is out, plus pipeline margin.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register; valid stays high so back-to-back writes need no gap.
  task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register_write(idx, data);
  endtask

  // Pick a full register set, with extremes drawn often. The shape cycles with
  // the phase number so every waveform gets random coverage.
  task automatic write_random_settings(input int phase_no);
    logic [CfgDataW-1:0] data;
    data = ($urandom & ~32'h3) | 32'(lfo_shape_e'(phase_no % 4));
    cfg_write(REG_WAVE_SHAPE, data);
    case ($urandom_range(0, 4))
      0:       data = '0;
      1:       data = '1;
      2:       data = $urandom_range(1, 1 << 20);
      default: data = $urandom;
    endcase
    cfg_write(REG_PHASE_STEP, data);
    case ($urandom_range(0, 4))
      0:       data = '0;
      1:       data = 32'h03FF_FFFF;
      2:       data = $urandom;
      default: data = $urandom_range(0, 65536000);
    endcase
    cfg_write(REG_DEPTH_GAIN, data);
    case ($urandom_range(0, 4))
      0:       data = 32'h0400_0000;
      1:       data = 32'h03FF_FFFF;
      2:       data = $urandom;
      default: data = 32'($urandom_range(0, 131072000)) - 32'd65536000;
    endcase
    cfg_write(REG_OUTPUT_OFFSET, data);
    case ($urandom_range(0, 3))
      0:       data = '0;
      1:       data = '1;
      default: data = $urandom;
    endcase
    cfg_write(REG_START_PHASE, data);
    cfg_write(RegFirstUnmapped + 3'($urandom_range(0, 2)), $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern whose density is redrawn after each random-length stretch,
  // including stretches with no stall at all. Serve each long-hold request with
  // an unbroken run of stalled cycles.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   = hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LongHoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        pattern_left = $urandom_range(16, 96);
      end
      pattern_left = pattern_left - 1;
      out_stall_i  <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted output transaction must match the oldest
  // owed value.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_values.size() == 0) begin
        fault_count++;
        if (fault_count <= ReportLimit) begin
          $display("%0t: unexpected lfo_value %0d", $time, lfo_value_o);
        end
      end else begin
        oldest_value = pending_values.pop_front();
        if (lfo_value_o !== oldest_value) begin
          fault_count++;
          if (fault_count <= ReportLimit) begin
            $display("%0t: lfo_value mismatch: expected %0d, got %0d",
                     $time, oldest_value, lfo_value_o);
          end
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("low_frequency_oscillator_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int  sent;
    int  burst;
    int  gap;
    bit  paused;

    build_sine_quarter();

    // Hold reset, then release it on a clock edge.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table. Drain before the first write of a group and
    // drop the write valid after the last one.
    for (int r = 0; r < DirRows; r++) begin
      if (dir_rows[r].kind == DO_WRITE) begin
        if (r == 0 || dir_rows[r-1].kind != DO_WRITE) begin
          wait_until_idle();
        end
        cfg_write(dir_rows[r].idx, dir_rows[r].data);
        if (r == DirRows - 1 || dir_rows[r+1].kind != DO_WRITE) begin
          cfg_valid_i <= 1'b0;
        end
      end else begin
        offer_tick(dir_rows[r].restart, dir_rows[r].typed, dir_rows[r].value);
        if ($urandom_range(0, 2) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end
      end
    end

    // Random phases: new register set each phase, ticks in bursts.
    for (int p = 0; p < PhaseCount; p++) begin
      wait_until_idle();
      write_random_settings(p);
      sent   = 0;
      paused = 1'b0;
      while (sent < ItemsPerPhase) begin
        burst = $urandom_range(1, 16);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (p == 2 && sent == 0) begin
          // Hold off the receiver and keep offering so the pipeline backs up.
          hold_requests <= hold_requests + 1;
          burst = 60;
          gap   = 0;
        end
        send_burst(burst, gap);
        sent += burst;
        if (p == 5 && !paused && sent >= ItemsPerPhase / 2) begin
          // Pause mid-phase until the block has caught up, then carry on.
          wait_until_idle();
          paused = 1'b1;
        end
      end
    end

    wait_until_idle();
    if (fault_count == 0) begin
      $display("low_frequency_oscillator_tb: PASS");
    end else begin
      $display("low_frequency_oscillator_tb: FAIL");
    end
    $finish;
  end

endmodule
